// ----- hw/rtl/gpx_pkg.sv -----
// Shared types and constants of the GPIO expander register file.
// Holds the request/result payload structs, opcodes, addresses and control structs.
// Depends on nothing.
`timescale 1ns / 1ps

package gpx_pkg;

  localparam int PIN_COUNT = 14;

  // request and result payloads
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] write_data;
    logic [4:0] query_pin;
  } gpx_req_t;

  typedef struct packed {
    logic [7:0]           read_data;
    logic [15:0]          pin_duty;
    logic [PIN_COUNT-1:0] gpio_level;
    logic [PIN_COUNT-1:0] drive_enable;
    logic [PIN_COUNT-1:0] drive_value;
  } gpx_rsp_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_QUERY = 2'd3
  } gpx_op_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fetch;
    logic exec;
    logic finish;
  } gpx_cmd_t;

  // register addresses
  localparam logic [7:0] ADDR_ID      = 8'h00;
  localparam logic [7:0] ADDR_NAME    = 8'h02;
  localparam logic [7:0] ADDR_IN_LO   = 8'h07;
  localparam logic [7:0] ADDR_IN_HI   = 8'h08;
  localparam logic [7:0] ADDR_IRQ_LO  = 8'h11;
  localparam logic [7:0] ADDR_IRQ_HI  = 8'h12;
  localparam logic [7:0] ADDR_NARROW0 = 8'h15;
  localparam logic [7:0] ADDR_NARROW1 = 8'h18;
  localparam logic [7:0] ADDR_NARROW2 = 8'h24;
  localparam logic [7:0] ADDR_VREF_LO = 8'h27;
  localparam logic [7:0] ADDR_VREF_HI = 8'h28;
  localparam logic [7:0] ADDR_CMD     = 8'h29;
  localparam logic [7:0] ADDR_ONEWIRE = 8'h90;

  localparam logic [7:0] CMD_RESET    = 8'h3A;
  localparam logic [7:0] NARROW_MASK  = 8'h3F;
  localparam logic [7:0] OW_CLR_MASK  = 8'h7F;

  localparam logic [7:0]  DEF_ID      = 8'h01;
  localparam logic [7:0]  DEF_NAME    = 8'h57;
  localparam logic [15:0] DEF_FREQ    = 16'd500;
  localparam logic [15:0] DEF_VREF    = 16'd3300;

  // shadow bytes held in flops: dir, out, pull-up, pull-down, open-drain,
  // four pwm channel words and the pwm frequency word
  localparam int SHD_N    = 20;
  localparam int SHD_IW   = $clog2(SHD_N);
  localparam int SHD_DIR  = 0;
  localparam int SHD_OUT  = 2;
  localparam int SHD_PU   = 4;
  localparam int SHD_PD   = 6;
  localparam int SHD_OD   = 8;
  localparam int SHD_PWM  = 10;
  localparam int SHD_FREQ = 18;

  localparam int PWM_CH = 4;
  localparam logic [4:0] PWM_PIN [PWM_CH] = '{5'd8, 5'd7, 5'd10, 5'd9};

  // floor(d*65535/4095) = 16*d + floor(d/273); d/273 via reciprocal
  localparam logic [11:0] DUTY_RECIP = 12'd3841;
  localparam int          DUTY_SHIFT = 20;

endpackage

// ----- hw/rtl/gpx_ctrl.sv -----
// Sequencer of the GPIO expander register file: load, fetch, execute, finish.
// Drives the datapath command struct and the busy/done handshake.
// Depends on gpx_pkg.
`timescale 1ns / 1ps

module gpx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output gpx_pkg::gpx_cmd_t cmd_o
);
  import gpx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_comb begin
    cmd_o.load   = start_i && (state_q == S_IDLE);
    cmd_o.fetch  = (state_q == S_FETCH);
    cmd_o.exec   = (state_q == S_EXEC);
    cmd_o.finish = (state_q == S_FINISH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_FETCH;
            busy_q  <= 1'b1;
          end
        end
        S_FETCH: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/gpx_datapath.sv -----
// Datapath of the GPIO expander register file: byte memory with valid bits,
// shadow flops for pin and pwm registers, pointer logic and duty calculation.
// Depends on gpx_pkg; sequenced by gpx_ctrl.
`timescale 1ns / 1ps

module gpx_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpx_pkg::gpx_cmd_t cmd_i,
  input  gpx_pkg::gpx_req_t req_i,
  output gpx_pkg::gpx_rsp_t rsp_o
);
  import gpx_pkg::*;

  typedef enum logic [1:0] {
    DK_ZERO,
    DK_FULL,
    DK_PWM
  } duty_kind_e;

  typedef struct packed {
    logic              hit;
    logic [SHD_IW-1:0] idx;
  } shd_sel_t;

  function automatic shd_sel_t shd_map(input logic [7:0] a);
    shd_sel_t s;
    s.hit = 1'b1;
    s.idx = '0;
    if (a >= 8'h03 && a <= 8'h06) begin
      s.idx = SHD_IW'(a - 8'h03);
    end else if (a >= 8'h09 && a <= 8'h0C) begin
      s.idx = SHD_IW'(a - 8'h05);
    end else if (a >= 8'h13 && a <= 8'h14) begin
      s.idx = SHD_IW'(a - 8'h0B);
    end else if (a >= 8'h1B && a <= 8'h22) begin
      s.idx = SHD_IW'(a - 8'h11);
    end else if (a >= 8'h25 && a <= 8'h26) begin
      s.idx = SHD_IW'(a - 8'h13);
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  function automatic logic writable(input logic [7:0] a);
    return (a >= 8'h03 && a <= 8'h06) || (a >= 8'h09 && a <= 8'h10) ||
           (a >= 8'h13 && a <= 8'h15) || (a == ADDR_NARROW1) ||
           (a >= 8'h1B && a <= 8'h26) || (a >= 8'h30 && a <= ADDR_ONEWIRE);
  endfunction

  function automatic logic [7:0] mem_default(input logic [7:0] a);
    logic [7:0] v;
    case (a)
      ADDR_ID:      v = DEF_ID;
      ADDR_NAME:    v = DEF_NAME;
      ADDR_VREF_LO: v = DEF_VREF[7:0];
      ADDR_VREF_HI: v = DEF_VREF[15:8];
      default:      v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] shd_default(input int i);
    logic [7:0] v;
    if (i == SHD_FREQ) begin
      v = DEF_FREQ[7:0];
    end else if (i == SHD_FREQ + 1) begin
      v = DEF_FREQ[15:8];
    end else begin
      v = 8'h00;
    end
    return v;
  endfunction

  logic [7:0]  mem [256];
  logic [255:0] valid_q;
  logic [7:0]  rd_q;

  logic [7:0]  shd_q [SHD_N];
  logic [7:0]  shd_d [SHD_N];

  gpx_req_t    req_q;
  logic [7:0]  ptr_q, ptr_d;
  logic        phase_q, phase_d;
  logic [7:0]  rdata_q, rdata_d;
  duty_kind_e  kind_q, kind_d;
  logic [11:0] lvl_q, lvl_d;
  gpx_rsp_t    rsp_q;

  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic        valid_clr;
  logic [7:0]  mbyte;
  logic [7:0]  wval;
  shd_sel_t    sel;
  logic [15:0] dir_w, out_w, pu_w, pd_w, od_w, freq_w, in_w, cfg_w, pin_mask;
  logic        is_pwm;
  logic [3:0]  pin_lo;
  logic [23:0] prod;
  logic [3:0]  quot;
  logic [PIN_COUNT-1:0] en_w;

  always_comb begin
    dir_w  = {shd_q[SHD_DIR + 1], shd_q[SHD_DIR]};
    out_w  = {shd_q[SHD_OUT + 1], shd_q[SHD_OUT]};
    pu_w   = {shd_q[SHD_PU + 1], shd_q[SHD_PU]};
    pd_w   = {shd_q[SHD_PD + 1], shd_q[SHD_PD]};
    od_w   = {shd_q[SHD_OD + 1], shd_q[SHD_OD]};
    freq_w = {shd_q[SHD_FREQ + 1], shd_q[SHD_FREQ]};
    in_w   = (out_w & dir_w) | (pu_w & ~pd_w & ~dir_w);
  end

  // execute step: register access, pointer update and duty selection
  always_comb begin
    mbyte     = valid_q[ptr_q] ? rd_q : mem_default(ptr_q);
    sel       = shd_map(ptr_q);
    ptr_d     = ptr_q;
    phase_d   = phase_q;
    shd_d     = shd_q;
    mem_we    = 1'b0;
    mem_wdata = req_q.write_data;
    valid_clr = 1'b0;
    rdata_d   = 8'h00;
    kind_d    = DK_ZERO;
    lvl_d     = '0;
    wval      = req_q.write_data;
    pin_mask  = 16'(1) << req_q.write_data[3:0];
    pin_lo    = req_q.query_pin[3:0];
    is_pwm    = 1'b0;
    cfg_w     = '0;
    for (int ch = 0; ch < PWM_CH; ch++) begin
      if (PWM_PIN[ch] == req_q.query_pin) begin
        is_pwm = 1'b1;
        cfg_w  = {shd_q[SHD_PWM + 2 * ch + 1], shd_q[SHD_PWM + 2 * ch]};
      end
    end
    if (cmd_i.exec) begin
      case (req_q.opcode)
        OP_START: begin
          phase_d = 1'b1;
        end
        OP_WRITE: begin
          if (phase_q) begin
            ptr_d   = req_q.write_data;
            phase_d = 1'b0;
          end else begin
            ptr_d = 8'(ptr_q + 8'd1);
            if (ptr_q == ADDR_CMD) begin
              if (req_q.write_data == CMD_RESET) begin
                valid_clr = 1'b1;
                ptr_d     = 8'h00;
                for (int i = 0; i < SHD_N; i++) begin
                  shd_d[i] = shd_default(i);
                end
              end
            end else if (ptr_q == ADDR_IRQ_LO || ptr_q == ADDR_IRQ_HI) begin
              // interrupt status clears where zeros are written
              mem_we    = 1'b1;
              mem_wdata = mbyte & req_q.write_data;
            end else if (writable(ptr_q)) begin
              if (ptr_q == ADDR_NARROW0 || ptr_q == ADDR_NARROW1 ||
                  ptr_q == ADDR_NARROW2) begin
                wval = req_q.write_data & NARROW_MASK;
              end else if (ptr_q == ADDR_ONEWIRE && req_q.write_data[7]) begin
                if (req_q.write_data[4:0] < 5'(PIN_COUNT)) begin
                  shd_d[SHD_DIR]     = shd_q[SHD_DIR] | pin_mask[7:0];
                  shd_d[SHD_DIR + 1] = shd_q[SHD_DIR + 1] | pin_mask[15:8];
                  shd_d[SHD_OUT]     = shd_q[SHD_OUT] | pin_mask[7:0];
                  shd_d[SHD_OUT + 1] = shd_q[SHD_OUT + 1] | pin_mask[15:8];
                end
                wval = req_q.write_data & OW_CLR_MASK;
              end
              if (sel.hit) begin
                shd_d[sel.idx] = wval;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = wval;
              end
            end
          end
        end
        OP_READ: begin
          ptr_d = 8'(ptr_q + 8'd1);
          if (ptr_q == ADDR_IN_LO) begin
            rdata_d = in_w[7:0];
          end else if (ptr_q == ADDR_IN_HI) begin
            rdata_d = {2'b00, in_w[13:8]};
          end else if (sel.hit) begin
            rdata_d = shd_q[sel.idx];
          end else begin
            rdata_d = mbyte;
          end
        end
        OP_QUERY: begin
          if (req_q.query_pin >= 5'(PIN_COUNT) || !dir_w[pin_lo]) begin
            kind_d = DK_ZERO;
          end else if (is_pwm && cfg_w[15]) begin
            if (freq_w != 16'h0000) begin
              kind_d = DK_PWM;
              lvl_d  = cfg_w[14] ? ~cfg_w[11:0] : cfg_w[11:0];
            end
          end else if (out_w[pin_lo]) begin
            kind_d = DK_FULL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // finish step: 16*d is a shift, the small quotient lands in the low nibble
  always_comb begin
    prod = 24'(lvl_q) * 24'(DUTY_RECIP);
    quot = prod[DUTY_SHIFT +: 4];
    en_w = dir_w[PIN_COUNT-1:0] & ~(out_w[PIN_COUNT-1:0] & od_w[PIN_COUNT-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q] <= mem_wdata;
    end
    if (cmd_i.fetch) begin
      rd_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= 8'h00;
      phase_q <= 1'b0;
      for (int i = 0; i < SHD_N; i++) begin
        shd_q[i] <= shd_default(i);
      end
    end else begin
      if (valid_clr) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[ptr_q] <= 1'b1;
      end
      ptr_q   <= ptr_d;
      phase_q <= phase_d;
      shd_q   <= shd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      rdata_q <= rdata_d;
      kind_q  <= kind_d;
      lvl_q   <= lvl_d;
    end
    if (cmd_i.finish) begin
      rsp_q.read_data    <= rdata_q;
      case (kind_q)
        DK_PWM:  rsp_q.pin_duty <= {lvl_q, quot};
        DK_FULL: rsp_q.pin_duty <= 16'hFFFF;
        default: rsp_q.pin_duty <= 16'h0000;
      endcase
      rsp_q.gpio_level   <= dir_w[PIN_COUNT-1:0] & out_w[PIN_COUNT-1:0];
      rsp_q.drive_enable <= en_w;
      rsp_q.drive_value  <= out_w[PIN_COUNT-1:0] & en_w;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- hw/rtl/i2c_gpio_expander_registers.sv -----
// Top level of the GPIO expander register file.
// Instantiates gpx_ctrl and gpx_datapath; depends on gpx_pkg.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low; its
// result appears on rsp_o with done_o high for exactly one cycle and cannot
// be held off by the receiver. Between the two the controller steps through
// its states in order: fetch of the register byte at the pointer from the
// registered memory port, execution of the access, and finish, in which the
// duty reciprocal multiply is done and the result is registered onto rsp_o.
// busy drops in the cycle done_o is shown, so the next request may be
// accepted in that cycle; a new request is not taken while one is in flight.
// Reset and the 0x3A command take effect at once: the byte memory carries a
// valid bit per entry, so no clearing pass is needed.
module i2c_gpio_expander_registers (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  gpx_pkg::gpx_req_t req_i,
  output gpx_pkg::gpx_rsp_t rsp_o,
  output logic              done_o
);
  import gpx_pkg::*;

  gpx_cmd_t cmd;

  gpx_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  gpx_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- hw/rtl/gpx_checker.sv -----
// Port-level checks of the GPIO expander register file, bound to the top level.
// Depends on gpx_pkg and i2c_gpio_expander_registers.
`timescale 1ns / 1ps

module gpx_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input gpx_pkg::gpx_req_t req_i,
  input gpx_pkg::gpx_rsp_t rsp_i,
  input logic              done_i
);
  import gpx_pkg::*;

  // every accepted request is followed by its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |-> ##4 done_i)
    else $error("result strobe missing after accepted request");

  // busy is released exactly when the result is shown
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result strobe while busy");

  // busy only rises because a request was accepted
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_i) |-> $past(start_i))
    else $error("busy rose without a request");

  // a pin is only driven where its driver is enabled
  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> ((rsp_i.drive_value & ~rsp_i.drive_enable) == '0))
    else $error("drive value outside drive enable");

endmodule

bind i2c_gpio_expander_registers gpx_checker u_gpx_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .req_i   (req_i),
  .rsp_i   (rsp_o),
  .done_i  (done_o)
);
